// ----- rtl/uvg_pkg.sv -----
// Shared types, constants and microcode for the UUID v4 string generator.
package uvg_pkg;

    localparam int unsigned STATE_W = 64;
    localparam int unsigned HALF_W  = STATE_W / 2;
    localparam int unsigned CHAR_W  = 7;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned STEP_W  = 4;

    localparam logic [STATE_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [STATE_W-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [STATE_W-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;

    localparam logic [CHAR_W-1:0] CHAR_DASH   = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_FOUR   = 7'h34;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A_BASE = 7'h57;

    localparam logic [POS_W-1:0] POS_DASH_0   = 6'd8;
    localparam logic [POS_W-1:0] POS_DASH_1   = 6'd13;
    localparam logic [POS_W-1:0] POS_DASH_2   = 6'd18;
    localparam logic [POS_W-1:0] POS_DASH_3   = 6'd23;
    localparam logic [POS_W-1:0] POS_VERSION  = 6'd14;
    localparam logic [POS_W-1:0] POS_VARIANT  = 6'd19;
    localparam logic [POS_W-1:0] POS_LAST     = 6'd35;
    localparam logic [POS_W-1:0] POS_FIRST    = 6'd0;

    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT  = 4'd0;
    localparam step_t STEP_CHAR  = 4'd1;
    localparam step_t STEP_FIXED = 4'd13;

    typedef enum logic [1:0] {MUL_NONE, MUL_LL, MUL_LH, MUL_HL} mul_t;
    typedef enum logic {KSEL_A, KSEL_B} ksel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD_HI} acc_t;
    typedef enum logic [1:0] {X_HOLD, X_STEP, X_MIX27} x_t;
    typedef enum logic [1:0] {EMIT_NONE, EMIT_DRAW, EMIT_FIXED} emit_t;
    typedef enum logic [1:0] {JMP_NEXT, JMP_WAIT, JMP_IF_FIXED, JMP_CHAR_END} jmp_t;

    typedef struct packed {
        mul_t  mul;
        ksel_t ksel;
        acc_t  acc;
        x_t    x;
        emit_t emit;
        jmp_t  jmp;
        step_t target;
    } uword_t;

    // Control handed from the sequencer to the datapath each cycle.
    typedef struct packed {
        uword_t uw;
        logic   fire;
        logic   load_seed;
        logic   is_dash;
        logic   is_nineteen;
        logic   is_last;
    } ctl_t;

    localparam uword_t UW_NOP = '{
        mul: MUL_NONE, ksel: KSEL_A, acc: ACC_HOLD, x: X_HOLD,
        emit: EMIT_NONE, jmp: JMP_NEXT, target: STEP_WAIT
    };

    // Control store. Steps 2 to 11 compute one draw: advance the state, then two
    // 64-bit multiplies, each built from three 32x32 partial products.
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = UW_NOP;
        case (s)
            4'd0:  begin w.jmp = JMP_WAIT; w.target = STEP_CHAR; end
            4'd1:  begin w.jmp = JMP_IF_FIXED; w.target = STEP_FIXED; end
            4'd2:  w.x = X_STEP;
            4'd3:  begin w.mul = MUL_LL; w.ksel = KSEL_A; end
            4'd4:  begin w.mul = MUL_LH; w.ksel = KSEL_A; w.acc = ACC_LOAD; end
            4'd5:  begin w.mul = MUL_HL; w.ksel = KSEL_A; w.acc = ACC_ADD_HI; end
            4'd6:  w.acc = ACC_ADD_HI;
            4'd7:  w.x = X_MIX27;
            4'd8:  begin w.mul = MUL_LL; w.ksel = KSEL_B; end
            4'd9:  begin w.mul = MUL_LH; w.ksel = KSEL_B; w.acc = ACC_LOAD; end
            4'd10: begin w.mul = MUL_HL; w.ksel = KSEL_B; w.acc = ACC_ADD_HI; end
            4'd11: w.acc = ACC_ADD_HI;
            4'd12: begin w.emit = EMIT_DRAW; w.jmp = JMP_CHAR_END; w.target = STEP_CHAR; end
            4'd13: begin w.emit = EMIT_FIXED; w.jmp = JMP_CHAR_END; w.target = STEP_CHAR; end
            default: begin w.jmp = JMP_CHAR_END; w.target = STEP_WAIT; end
        endcase
        return w;
    endfunction

    function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] n);
        logic [CHAR_W-1:0] c;
        if (n < 4'd10)
            c = CHAR_ZERO + {3'b000, n};
        else
            c = CHAR_A_BASE + {3'b000, n};
        return c;
    endfunction

endpackage

// ----- rtl/uvg_req_if.sv -----
// Request channel: one beat with request set asks for one identifier string.
interface uvg_req_if;
    logic valid;
    logic ready;
    logic request;

    modport source (output valid, output request, input ready);
    modport sink (input valid, input request, output ready);
endinterface

// ----- rtl/uvg_char_if.sv -----
// Character channel: one beat carries one ASCII character of an identifier.
interface uvg_char_if;
    logic                        valid;
    logic                        ready;
    logic [uvg_pkg::CHAR_W-1:0]  char_code;
    logic                        last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/uuid_v4_string_generator_top.sv -----
// Top level of the UUID v4 string generator.
//
// A beat on req with request set asks for one identifier; the block answers with
// 36 beats on result, one lowercase hex digit or dash each, last_char set on
// the final one. A request beat with request clear is taken and ignored.
// req is ready only between strings, so one string is produced at a time.
// Each hex digit takes 12 microcode steps: a dispatch step, one generator draw
// (a 64-bit add, then two 64-bit multiplies done as three partial products each
// on a single 32x32 multiplier) and an emit step. Dashes and the version digit
// take 2 steps. Once the last character is loaded into the output register, req
// is ready again in the next cycle. result has a one-beat output register; while
// it is stalled the sequencer holds at its emit step and no state is lost.
// seed_reg is written on cfg_wr_en/cfg_wr_data; the user must write it only while
// the block is idle, and nothing in the block enforces this.
// Reset clears the seed to zero and marks the generator unseeded; the first
// request after reset loads the state from the seed.
module uuid_v4_string_generator_top
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [uvg_pkg::STATE_W-1:0]  cfg_wr_data,
    uvg_req_if.sink                      req,
    uvg_char_if.source                   result
);

    uvg_pkg::ctl_t ctl;
    logic          out_free;

    uvg_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .out_free (out_free),
        .ctl      (ctl)
    );

    uvg_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ctl         (ctl),
        .out_free    (out_free),
        .result      (result)
    );

endmodule

// ----- rtl/uvg_sequencer.sv -----
// Microcode sequencer: step counter, character position and branch logic.
module uvg_sequencer
(
    input  logic          clk,
    input  logic          rst_n,
    uvg_req_if.sink       req,
    input  logic          out_free,
    output uvg_pkg::ctl_t ctl
);

    uvg_pkg::step_t             step_reg, step_next;
    logic [uvg_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic                       seeded_reg, seeded_next;
    uvg_pkg::uword_t            uw;
    logic                       start;
    logic                       is_dash;
    logic                       is_four;
    logic                       is_last;
    logic                       fire;

    assign uw        = uvg_pkg::ucode(step_reg);
    assign req.ready = (step_reg == uvg_pkg::STEP_WAIT);
    assign start     = req.valid && req.ready && req.request;

    assign is_dash = pos_reg inside {uvg_pkg::POS_DASH_0, uvg_pkg::POS_DASH_1,
                                     uvg_pkg::POS_DASH_2, uvg_pkg::POS_DASH_3};
    assign is_four = (pos_reg == uvg_pkg::POS_VERSION);
    assign is_last = (pos_reg == uvg_pkg::POS_LAST);

    // Only an emitting step can stall, and only while the output beat is held.
    assign fire = (uw.emit == uvg_pkg::EMIT_NONE) || out_free;

    always_comb
    begin
        ctl.uw          = uw;
        ctl.fire        = fire;
        ctl.load_seed   = start && !seeded_reg;
        ctl.is_dash     = is_dash;
        ctl.is_nineteen = (pos_reg == uvg_pkg::POS_VARIANT);
        ctl.is_last     = is_last;
    end

    always_comb
    begin
        step_next   = step_reg + 4'd1;
        pos_next    = pos_reg;
        seeded_next = seeded_reg;
        case (uw.jmp)
            uvg_pkg::JMP_NEXT:
                step_next = step_reg + 4'd1;
            uvg_pkg::JMP_WAIT:
            begin
                step_next = start ? uw.target : step_reg;
                if (start)
                begin
                    pos_next    = uvg_pkg::POS_FIRST;
                    seeded_next = 1'b1;
                end
            end
            uvg_pkg::JMP_IF_FIXED:
                step_next = (is_dash || is_four) ? uw.target : step_reg + 4'd1;
            uvg_pkg::JMP_CHAR_END:
            begin
                if (!fire)
                    step_next = step_reg;
                else if (is_last)
                begin
                    step_next = uvg_pkg::STEP_WAIT;
                    pos_next  = uvg_pkg::POS_FIRST;
                end
                else
                begin
                    step_next = uw.target;
                    pos_next  = pos_reg + 6'd1;
                end
            end
            default:
                step_next = uvg_pkg::STEP_WAIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= uvg_pkg::STEP_WAIT;
            pos_reg    <= uvg_pkg::POS_FIRST;
            seeded_reg <= 1'b0;
        end
        else
        begin
            step_reg   <= step_next;
            pos_reg    <= pos_next;
            seeded_reg <= seeded_next;
        end
    end

endmodule

// ----- rtl/uvg_datapath.sv -----
// Datapath: seed and generator state, shared 32x32 multiplier, output register.
module uvg_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [uvg_pkg::STATE_W-1:0]  cfg_wr_data,
    input  uvg_pkg::ctl_t                ctl,
    output logic                         out_free,
    uvg_char_if.source                   result
);

    logic [uvg_pkg::STATE_W-1:0] seed_reg, seed_next;
    logic [uvg_pkg::STATE_W-1:0] state_reg, state_next;
    logic [uvg_pkg::STATE_W-1:0] x_reg, x_next;
    logic [uvg_pkg::STATE_W-1:0] acc_reg, acc_next;
    logic [uvg_pkg::STATE_W-1:0] prod_reg, prod_next;
    logic                        out_valid_reg, out_valid_next;
    logic [uvg_pkg::CHAR_W-1:0]  char_reg, char_next;
    logic                        last_reg, last_next;

    logic [uvg_pkg::STATE_W-1:0] k;
    logic [uvg_pkg::HALF_W-1:0]  mul_a;
    logic [uvg_pkg::HALF_W-1:0]  mul_b;
    logic [uvg_pkg::STATE_W-1:0] step_sum;
    logic [3:0]                  draw_nib;
    logic [3:0]                  digit;
    logic                        emit;

    assign out_free = !out_valid_reg || result.ready;
    assign emit     = ctl.fire && (ctl.uw.emit != uvg_pkg::EMIT_NONE);

    assign k        = (ctl.uw.ksel == uvg_pkg::KSEL_A) ? uvg_pkg::MIX_MUL_A : uvg_pkg::MIX_MUL_B;
    assign mul_a    = (ctl.uw.mul == uvg_pkg::MUL_HL) ? x_reg[63:32] : x_reg[31:0];
    assign mul_b    = (ctl.uw.mul == uvg_pkg::MUL_LH) ? k[63:32] : k[31:0];
    assign step_sum = state_reg + uvg_pkg::GOLDEN_INC;

    // Only the low nibble of the final xor-shift is ever used.
    assign draw_nib = acc_reg[3:0] ^ acc_reg[34:31];
    assign digit    = ctl.is_nineteen ? {2'b10, draw_nib[1:0]} : draw_nib;

    always_comb
    begin
        seed_next = cfg_wr_en ? cfg_wr_data : seed_reg;

        state_next = state_reg;
        x_next     = x_reg;
        if (ctl.load_seed)
            state_next = seed_reg;
        else if (ctl.uw.x == uvg_pkg::X_STEP)
        begin
            state_next = step_sum;
            x_next     = step_sum ^ (step_sum >> 30);
        end
        else if (ctl.uw.x == uvg_pkg::X_MIX27)
            x_next = acc_reg ^ (acc_reg >> 27);

        prod_next = prod_reg;
        if (ctl.uw.mul != uvg_pkg::MUL_NONE)
            prod_next = {32'b0, mul_a} * {32'b0, mul_b};

        case (ctl.uw.acc)
            uvg_pkg::ACC_LOAD:   acc_next = prod_reg;
            uvg_pkg::ACC_ADD_HI: acc_next = acc_reg + {prod_reg[31:0], 32'b0};
            default:             acc_next = acc_reg;
        endcase

        out_valid_next = out_valid_reg && !result.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            last_next      = ctl.is_last;
            if (ctl.uw.emit == uvg_pkg::EMIT_DRAW)
                char_next = uvg_pkg::hex_char(digit);
            else
                char_next = ctl.is_dash ? uvg_pkg::CHAR_DASH : uvg_pkg::CHAR_FOUR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seed_reg      <= seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        x_reg     <= x_next;
        acc_reg   <= acc_next;
        prod_reg  <= prod_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    assign result.valid     = out_valid_reg;
    assign result.char_code = char_reg;
    assign result.last_char = last_reg;

endmodule
